/* sv/bsfp_pkg.sv */
// Shared types, constants and helpers for the base status frame parser.
package bsfp_pkg;

  // Default payload length of one frame, sync bytes not counted
  localparam int FRAME_BYTES_DEFAULT = 33;

  // Only the leading bytes of a frame feed decoded fields
  localparam int STORE_BYTES = 32;
  localparam int STORE_IDX_W = $clog2(STORE_BYTES);

  localparam logic [7:0]  SYNC_BYTE      = 8'hFE;
  localparam logic [16:0] WORD_BIAS      = 17'd10000;
  localparam logic [3:0]  BACKUP_NIBBLE  = 4'h3;
  localparam logic [7:0]  VEL_OFFSET     = 8'h80;
  localparam logic [14:0] DEADBAND_RESET = 15'd10;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Frame status codes
  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_STALL = 2'd1;
  localparam logic [1:0] ST_CKSUM = 2'd2;

  typedef logic [STORE_BYTES-1:0][7:0] frame_bytes_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic [1:0]   status;
    logic [3:0]   wheels;
    frame_bytes_t bytes;
  } frame_t;

  // Decoded result item
  typedef struct packed {
    logic [1:0]         frame_status;
    logic [3:0]         stalled_wheels;
    logic signed [7:0]  vel_x;
    logic signed [7:0]  vel_y;
    logic signed [7:0]  vel_turn;
    logic [50:0]        accel_packed;
    logic [50:0]        gyro_packed;
    logic [7:0]         battery_level;
    logic [7:0]         backup_level;
    logic [31:0]        tilt_packed;
    logic signed [15:0] yaw_now;
    logic signed [31:0] heading_total;
  } result_t;

  // Little-endian word minus bias, as 17-bit two's complement
  function automatic logic [16:0] word17(input logic [7:0] lo, input logic [7:0] hi);
    return {1'b0, hi, lo} - WORD_BIAS;
  endfunction

endpackage

/* sv/bsfp_front.sv */
// Front part: sync hunt, frame capture, running checksum and classification.
module bsfp_front #(
  parameter int FRAME_BYTES = bsfp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        rx_byte,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output bsfp_pkg::frame_t  q_data
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  localparam logic [1:0] PH_SEEK1   = 2'd0;
  localparam logic [1:0] PH_SEEK2   = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [1:0]             phase;
  logic [IDX_W-1:0]       idx;
  logic [7:0]             sum;
  bsfp_pkg::frame_bytes_t store;

  logic       accept;
  logic       last;
  logic [9:0] stall_sum;
  logic       stall;
  logic [3:0] mask;

  // Hold off the sender whenever the queue has no room
  assign full   = q_full;
  assign accept = push && !q_full;
  assign last   = (phase == PH_COLLECT) && (idx == LAST_IDX);
  assign q_push = accept && last;

  // Classify the frame as its last byte arrives
  always_comb begin
    stall_sum = 10'(store[0]) + 10'(store[1]) + 10'(store[2]) + 10'(store[3]);
    stall     = (stall_sum == 10'(store[4]));
    for (int i = 0; i < 4; i++) begin
      mask[i] = (store[i] == 8'd1);
    end
    if (stall) begin
      q_data.status = bsfp_pkg::ST_STALL;
    end else if (sum == rx_byte) begin
      q_data.status = bsfp_pkg::ST_GOOD;
    end else begin
      q_data.status = bsfp_pkg::ST_CKSUM;
    end
    q_data.wheels = stall ? mask : 4'd0;
    q_data.bytes  = store;
  end

  // Advance the hunt state, byte index and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK1;
      idx   <= '0;
      sum   <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_SEEK2: begin
          if (rx_byte == bsfp_pkg::SYNC_BYTE) begin
            phase <= PH_COLLECT;
            idx   <= '0;
            sum   <= '0;
          end
        end
        PH_COLLECT: begin
          if (last) begin
            phase <= PH_SEEK1;
            idx   <= '0;
            sum   <= '0;
          end else begin
            idx <= idx + 1'b1;
            sum <= sum + rx_byte;
          end
        end
        default: begin
          phase <= (rx_byte == bsfp_pkg::SYNC_BYTE) ? PH_SEEK2 : PH_SEEK1;
        end
      endcase
    end
  end

  // Capture the bytes that feed decoded fields
  always_ff @(posedge clk) begin
    if (accept && phase == PH_COLLECT && !last && idx < IDX_W'(bsfp_pkg::STORE_BYTES)) begin
      store[idx[bsfp_pkg::STORE_IDX_W-1:0]] <= rx_byte;
    end
  end

  // A frame is queued only on the last byte of a collection
  a_push_on_last: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (phase == PH_COLLECT && idx == LAST_IDX && !q_full))
    else $error("frame queued outside the last byte");

endmodule

/* sv/bsfp_queue.sv */
// Short queue of classified frames between front and back.
module bsfp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsfp_pkg::frame_t data_in,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output bsfp_pkg::frame_t data_out
);

  localparam int DEPTH = bsfp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bsfp_pkg::frame_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign do_wr    = push && !full;
  assign do_rd    = pop && valid;
  assign data_out = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store incoming item
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= data_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !push) |=> (count == '0))
    else $error("queue count changed without an item");

endmodule

/* sv/bsfp_back.sv */
// Back part: field decode, dead-banded heading update and output register.
module bsfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  bsfp_pkg::frame_t  q_data,
  output logic              q_pop,
  input  logic [14:0]       deadband,
  output logic              empty,
  input  logic              pop,
  output bsfp_pkg::result_t res
);

  logic               out_valid;
  logic               take;
  logic               good;
  logic               yaw_seen;
  logic signed [15:0] prior_yaw;
  logic signed [31:0] heading_sum;

  logic signed [15:0] yaw;
  logic signed [16:0] delta_raw;
  logic signed [16:0] delta;
  logic [16:0]        mag;
  logic signed [31:0] heading_next;
  bsfp_pkg::frame_bytes_t b;
  bsfp_pkg::result_t  res_next;

  assign take  = q_valid && (!out_valid || pop);
  assign q_pop = take;
  assign empty = !out_valid;
  assign good  = (q_data.status == bsfp_pkg::ST_GOOD);
  assign b     = q_data.bytes;

  // Apply the dead band to the yaw change and accumulate heading
  always_comb begin
    yaw       = {b[30], b[31]};
    delta_raw = yaw_seen ? (17'(yaw) - 17'(prior_yaw)) : '0;
    mag       = delta_raw[16] ? $unsigned(-delta_raw) : $unsigned(delta_raw);
    delta     = (mag < {2'b00, deadband}) ? '0 : delta_raw;
    heading_next = heading_sum + 32'(delta);
  end

  // Decode fields; only good frames carry telemetry
  always_comb begin
    res_next = '0;
    res_next.frame_status   = q_data.status;
    res_next.stalled_wheels = q_data.wheels;
    if (good) begin
      res_next.vel_x    = b[0] ^ bsfp_pkg::VEL_OFFSET;
      res_next.vel_y    = b[1] ^ bsfp_pkg::VEL_OFFSET;
      res_next.vel_turn = b[2] ^ bsfp_pkg::VEL_OFFSET;
      res_next.accel_packed = {bsfp_pkg::word17(b[7], b[8]),
                               bsfp_pkg::word17(b[5], b[6]),
                               bsfp_pkg::word17(b[3], b[4])};
      res_next.gyro_packed  = {bsfp_pkg::word17(b[13], b[14]),
                               bsfp_pkg::word17(b[11], b[12]),
                               bsfp_pkg::word17(b[9], b[10])};
      res_next.battery_level = b[16];
      res_next.backup_level  = (b[15][7:4] == bsfp_pkg::BACKUP_NIBBLE) ? b[17] : 8'd0;
      res_next.tilt_packed   = {b[28], b[29], b[26], b[27]};
      res_next.yaw_now       = yaw;
      res_next.heading_total = heading_next;
    end
  end

  // Hold output valid and heading state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      yaw_seen    <= 1'b0;
      prior_yaw   <= '0;
      heading_sum <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (take && good) begin
        yaw_seen    <= 1'b1;
        prior_yaw   <= yaw;
        heading_sum <= heading_next;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(res)))
    else $error("waiting result changed before it was taken");

  a_heading_only_good: assert property (@(posedge clk) disable iff (rst)
    !(take && good) |=> $stable(heading_sum))
    else $error("heading moved without a good frame");

endmodule

/* sv/base_status_frame_parser.sv */
// Top level of the base status frame parser: config register and part wiring.
//
// Takes one received byte per clock cycle while full is low, no gaps required.
// After two 0xFE sync bytes it collects FRAME_BYTES bytes and yields one
// result per frame: good telemetry, a motor stall report, or a checksum
// failure. The edge that takes the frame's last byte classifies the frame
// and writes it into the two-entry frame queue; the back's output register
// then loads it once that register is empty or is being popped.
// full rises only when the output register and both queue entries hold frames
// that have not been popped. The dead band register may be written at any
// time the channel is valid (ready is always high); it should be changed only
// while no frame is in flight.
module base_status_frame_parser #(
  parameter int FRAME_BYTES = bsfp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         rx_byte,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         frame_status,
  output logic [3:0]         stalled_wheels,
  output logic signed [7:0]  vel_x,
  output logic signed [7:0]  vel_y,
  output logic signed [7:0]  vel_turn,
  output logic [50:0]        accel_packed,
  output logic [50:0]        gyro_packed,
  output logic [7:0]         battery_level,
  output logic [7:0]         backup_level,
  output logic [31:0]        tilt_packed,
  output logic signed [15:0] yaw_now,
  output logic signed [31:0] heading_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);

  logic [14:0]       yaw_deadband;
  logic              f_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  bsfp_pkg::frame_t  f_data;
  bsfp_pkg::frame_t  q_head;
  bsfp_pkg::result_t res;

  // Write the dead band register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_deadband <= bsfp_pkg::DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      yaw_deadband <= cfg_data;
    end
  end

  bsfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .q_full  (q_full),
    .q_push  (f_push),
    .q_data  (f_data)
  );

  bsfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .data_in  (f_data),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .data_out (q_head)
  );

  bsfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .deadband (yaw_deadband),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  // Break the result item out onto its ports
  assign frame_status   = res.frame_status;
  assign stalled_wheels = res.stalled_wheels;
  assign vel_x          = res.vel_x;
  assign vel_y          = res.vel_y;
  assign vel_turn       = res.vel_turn;
  assign accel_packed   = res.accel_packed;
  assign gyro_packed    = res.gyro_packed;
  assign battery_level  = res.battery_level;
  assign backup_level   = res.backup_level;
  assign tilt_packed    = res.tilt_packed;
  assign yaw_now        = res.yaw_now;
  assign heading_total  = res.heading_total;

endmodule
